/* sv/rpn_pkg.sv */
`timescale 1ns / 1ps

package rpn_pkg;

	// sizes
	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 3;

	// divider: scaled dividend, quotient bits resolved by iteration, step counter
	localparam int NUM_W = DATA_W + FRAC_BITS;
	localparam int QUO_W = DATA_W + 1;
	localparam int CNT_W = $clog2(QUO_W + 1);

	// magnitude width wide enough for a rounded product
	localparam int MAG_W = 2 * DATA_W + 1;

	localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(1) << (DATA_W - 1);
	localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - MAG_W'(1);

	localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

	// operation codes
	typedef logic [FUNC_W-1:0] func_t;
	localparam func_t FN_PUSH  = FUNC_W'(0);
	localparam func_t FN_ADD   = FUNC_W'(1);
	localparam func_t FN_SUB   = FUNC_W'(2);
	localparam func_t FN_MUL   = FUNC_W'(3);
	localparam func_t FN_DIV   = FUNC_W'(4);
	localparam func_t FN_CLEAR = FUNC_W'(5);

	// result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t STS_OK      = STATUS_W'(0);
	localparam status_t STS_MISSING = STATUS_W'(1);
	localparam status_t STS_DIVZERO = STATUS_W'(2);
	localparam status_t STS_FULL    = STATUS_W'(3);
	localparam status_t STS_SAT     = STATUS_W'(4);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_DIV,
		S_COMMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_prod;
		logic div_start;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic out_free;
	} ctrl_sts_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} sat_res_t;

	// absolute value, most negative value maps to its own unsigned pattern
	function automatic logic [DATA_W-1:0] mag_of(logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
	endfunction

	// rebuild a signed value from sign and magnitude, saturating
	function automatic sat_res_t from_mag(logic neg, logic [MAG_W-1:0] mag);
		sat_res_t r;
		r.sat = 1'b0;
		r.val = '0;
		if (neg) begin
			if (mag > MAG_NEG_LIM) begin
				r.sat = 1'b1;
				r.val = VAL_MIN;
			end else begin
				r.val = DATA_W'(MAG_W'(0) - mag);
			end
		end else begin
			if (mag > MAG_POS_LIM) begin
				r.sat = 1'b1;
				r.val = VAL_MAX;
			end else begin
				r.val = DATA_W'(mag);
			end
		end
		return r;
	endfunction

	// clamp a one-bit-grown sum back to the data width
	function automatic sat_res_t clamp_sum(logic [DATA_W:0] s);
		sat_res_t r;
		r.sat = s[DATA_W] != s[DATA_W-1];
		if (r.sat) begin
			r.val = s[DATA_W] ? VAL_MIN : VAL_MAX;
		end else begin
			r.val = s[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/rpn_in_if.sv */
`timescale 1ns / 1ps

interface rpn_in_if
	import rpn_pkg::*;
();
	logic                     valid;
	logic                     ready;
	func_t                    func;
	logic signed [DATA_W-1:0] operand;

	modport source (output valid, output func, output operand, input ready);
	modport sink (input valid, input func, input operand, output ready);
endinterface

/* sv/rpn_out_if.sv */
`timescale 1ns / 1ps

interface rpn_out_if
	import rpn_pkg::*;
();
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] top_value;
	logic [DEPTH_W-1:0]       stack_depth;

	modport source (output valid, output status, output top_value, output stack_depth,
		input ready);
	modport sink (input valid, input status, input top_value, input stack_depth,
		output ready);
endinterface

/* sv/rpn_stack_calculator.sv */
`timescale 1ns / 1ps
// sequence: each word is captured in S_IDLE and goes through S_DECIDE to S_COMMIT, where
// its result word is registered; divide waits in S_DIV between them while the divider
// resolves one quotient bit a cycle; throughput: one word at a time, the next word is
// taken once the result is registered, and S_COMMIT waits until the output is free
// reset: arst_n clears the controller, the stack pointer and the output valid at once

module rpn_stack_calculator
	import rpn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rpn_in_if.sink    req,
	rpn_out_if.source rsp
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpn_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.func    (req.func),
		.operand (req.operand),
		.rsp     (rsp)
	);

endmodule

/* sv/rpn_div.sv */
`timescale 1ns / 1ps

module rpn_div
	import rpn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DATA_W-1:0]  dividend,
	input  logic [DATA_W-1:0]  divisor,
	output logic               busy,
	output logic [QUO_W-1:0]   quot,
	output logic               ovf
);

	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [QUO_W-1:0]  sh_q;
	logic              ovf_q;

	logic [NUM_W-1:0]  num_w;
	logic [NUM_W-1:0]  num_hi_w;
	logic              hi_ge;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              take;

	// scaled dividend; bits above the quotient window seed the remainder and decide overflow
	assign num_w    = NUM_W'(dividend) << FRAC_BITS;
	assign num_hi_w = num_w >> QUO_W;
	assign hi_ge    = num_hi_w >= NUM_W'(divisor);

	// one restoring step per cycle, quotient bits shift in from the bottom
	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi_w[DATA_W-1:0];
			sh_q  <= QUO_W'(num_w);
			dvs_q <= divisor;
			ovf_q <= hi_ge;
		end else if (busy) begin
			rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], take};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = sh_q;
	assign ovf  = ovf_q;

endmodule

/* sv/rpn_dp.sv */
`timescale 1ns / 1ps

module rpn_dp
	import rpn_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output ctrl_sts_t                sts,
	input  func_t                    func,
	input  logic signed [DATA_W-1:0] operand,
	rpn_out_if.source                rsp
);

	logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];

	func_t               func_q;
	logic [DATA_W-1:0]   opnd_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [DATA_W-1:0]   top_q;
	logic [DATA_W-1:0]   lft_q;
	logic [2*DATA_W-1:0] prod_s1;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [DATA_W-1:0]   out_top_q;
	logic [DEPTH_W-1:0]  out_depth_q;

	logic [PTR_W-1:0]    rd_addr;
	logic [DATA_W-1:0]   lmag;
	logic [DATA_W-1:0]   rmag;
	logic                neg;
	logic                few;
	logic                r_zero;
	logic                out_free;

	logic                div_busy;
	logic [QUO_W-1:0]    div_quot;
	logic                div_ovf;

	logic [DATA_W:0]     sum_w;
	logic [DATA_W:0]     dif_w;
	logic [2*DATA_W:0]   rnd_w;
	logic [MAG_W-1:0]    mul_mag;
	logic [MAG_W-1:0]    div_mag;
	sat_res_t            op_res;

	logic                mem_we;
	logic [PTR_W-1:0]    mem_wa;
	logic [DATA_W-1:0]   mem_wd;
	logic [DEPTH_W-1:0]  nxt_depth;
	logic [DATA_W-1:0]   nxt_top;
	status_t             nxt_status;

	// left operand sits one below the top, the top itself is kept in top_q
	assign rd_addr = PTR_W'(depth_q - DEPTH_W'(2));
	assign lmag    = mag_of(lft_q);
	assign rmag    = mag_of(top_q);
	assign neg     = lft_q[DATA_W-1] ^ top_q[DATA_W-1];
	assign few     = depth_q < DEPTH_W'(2);
	assign r_zero  = top_q == '0;

	// operand stack write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
	end

	// operand stack read port, left operand fetched as the word is taken
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lft_q <= stack_mem[rd_addr];
		end
	end

	// captured input word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			opnd_q <= operand;
		end
	end

	// magnitude product
	always_ff @(posedge clk) begin
		if (cmd.load_prod) begin
			prod_s1 <= lmag * rmag;
		end
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (lmag),
		.divisor  (rmag),
		.busy     (div_busy),
		.quot     (div_quot),
		.ovf      (div_ovf)
	);

	// arithmetic results
	assign sum_w   = {lft_q[DATA_W-1], lft_q} + {top_q[DATA_W-1], top_q};
	assign dif_w   = {lft_q[DATA_W-1], lft_q} - {top_q[DATA_W-1], top_q};
	assign rnd_w   = {prod_s1, 1'b0} >> FRAC_BITS;
	assign mul_mag = MAG_W'(rnd_w[2*DATA_W:1]) + MAG_W'(rnd_w[0]);
	assign div_mag = div_ovf ? '1 : MAG_W'(div_quot);

	always_comb begin
		case (func_q)
			FN_ADD:  op_res = clamp_sum(sum_w);
			FN_SUB:  op_res = clamp_sum(dif_w);
			FN_MUL:  op_res = from_mag(neg, mul_mag);
			default: op_res = from_mag(neg, div_mag);
		endcase
	end

	// stack update for the word in hand
	always_comb begin
		mem_we     = 1'b0;
		mem_wa     = depth_q[PTR_W-1:0];
		mem_wd     = opnd_q;
		nxt_depth  = depth_q;
		nxt_top    = top_q;
		nxt_status = STS_OK;
		case (func_q)
			FN_PUSH: begin
				if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
					mem_we    = cmd.commit;
					nxt_depth = depth_q + DEPTH_W'(1);
					nxt_top   = opnd_q;
				end else begin
					nxt_status = STS_FULL;
				end
			end
			FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
				if (few) begin
					nxt_depth  = '0;
					nxt_top    = '0;
					nxt_status = STS_MISSING;
				end else if (func_q == FN_DIV && r_zero) begin
					nxt_depth  = '0;
					nxt_top    = '0;
					nxt_status = STS_DIVZERO;
				end else begin
					mem_we     = cmd.commit;
					mem_wa     = rd_addr;
					mem_wd     = op_res.val;
					nxt_depth  = depth_q - DEPTH_W'(1);
					nxt_top    = op_res.val;
					nxt_status = op_res.sat ? STS_SAT : STS_OK;
				end
			end
			FN_CLEAR: begin
				nxt_depth = '0;
				nxt_top   = '0;
			end
			default: begin
				nxt_depth = depth_q;
			end
		endcase
	end

	// stack pointer and top of stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			top_q   <= '0;
		end else if (cmd.commit) begin
			depth_q <= nxt_depth;
			top_q   <= nxt_top;
		end
	end

	// output register
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= nxt_status;
			out_top_q    <= nxt_top;
			out_depth_q  <= nxt_depth;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.top_value   = out_top_q;
	assign rsp.stack_depth = out_depth_q;

	assign sts.need_div = (func_q == FN_DIV) && !few && !r_zero;
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;

`ifndef ASSERT_OFF
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack size");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q == '0) |-> (top_q == '0))
		else $error("empty stack with nonzero top");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free)
		else $error("result written over an untaken word");
`endif

endmodule

/* sv/rpn_ctrl.sv */
`timescale 1ns / 1ps

module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = sts.need_div ? S_DIV : S_COMMIT;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd.capture   = 1'b0;
		cmd.load_prod = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_DECIDE: begin
				cmd.load_prod = 1'b1;
				cmd.div_start = sts.need_div;
			end
			S_DIV: begin
				cmd.load_prod = 1'b0;
			end
			S_COMMIT: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import rpn_pkg::*;

	// codes the block leaves unused
	localparam func_t FN_SPARE_LO = FUNC_W'(6);
	localparam func_t FN_SPARE_HI = FUNC_W'(7);

	// handy Q16.16 values
	localparam logic [DATA_W-1:0] Q_ONE       = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_HALF      = 32'h0000_8000;
	localparam logic [DATA_W-1:0] Q_NEG_HALF  = 32'hFFFF_8000;
	localparam logic [DATA_W-1:0] Q_NEG_THREE = 32'hFFFD_0000;
	localparam logic [DATA_W-1:0] Q_LSB       = 32'h0000_0001;
	localparam logic [DATA_W-1:0] Q_ALL_ONES  = 32'hFFFF_FFFF;

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	localparam int IDLE_PCT      = 23;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int RUN_LIMIT_NS  = 2_000_000;

	typedef struct packed {
		status_t            status;
		logic [DATA_W-1:0]  top_value;
		logic [DEPTH_W-1:0] stack_depth;
	} rpn_result_t;

	logic clk;
	logic arst_n;

	rpn_in_if  req_if ();
	rpn_out_if rsp_if ();

	rpn_stack_calculator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// predicted stack contents and depth
	logic [DATA_W-1:0] model_stack [STACK_DEPTH];
	int                depth_cnt = 0;

	rpn_result_t pending_results [$];
	int          mismatch_count = 0;
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("rpn_stack_calculator verification failed");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// saturate a wide signed value to one word
	function automatic logic [DATA_W-1:0] clamp_to_word(longint v, output logic sat);
		sat = 1'b1;
		if (v > WORD_MAX) begin
			return VAL_MAX;
		end
		if (v < WORD_MIN) begin
			return VAL_MIN;
		end
		sat = 1'b0;
		return DATA_W'(v);
	endfunction

	function automatic logic [63:0] magnitude_of(logic [DATA_W-1:0] v);
		longint s;
		s = longint'(signed'(v));
		return (s < 0) ? 64'(-s) : 64'(s);
	endfunction

	function automatic logic [DATA_W-1:0] apply_sign(logic neg, logic [63:0] mag,
		output logic sat);
		longint s;
		s = neg ? -longint'(mag) : longint'(mag);
		return clamp_to_word(s, sat);
	endfunction

	// evaluate one word against the predicted stack
	function automatic rpn_result_t evaluate_word(func_t f, logic [DATA_W-1:0] opnd);
		rpn_result_t       res;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] value;
		logic [63:0]       prod;
		logic [63:0]       quo;
		logic              neg;
		logic              sat;
		res.status = STS_OK;
		sat = 1'b0;
		value = '0;
		case (f)
			FN_PUSH: begin
				if (depth_cnt < STACK_DEPTH) begin
					model_stack[depth_cnt] = opnd;
					depth_cnt++;
				end else begin
					res.status = STS_FULL;
				end
			end
			FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
				if (depth_cnt < 2) begin
					depth_cnt = 0;
					res.status = STS_MISSING;
				end else begin
					rhs = model_stack[depth_cnt-1];
					lhs = model_stack[depth_cnt-2];
					depth_cnt -= 2;
					neg = lhs[DATA_W-1] ^ rhs[DATA_W-1];
					case (f)
						FN_ADD: begin
							value = clamp_to_word(longint'(signed'(lhs)) +
								longint'(signed'(rhs)), sat);
						end
						FN_SUB: begin
							value = clamp_to_word(longint'(signed'(lhs)) -
								longint'(signed'(rhs)), sat);
						end
						FN_MUL: begin
							// round to nearest, ties away from zero
							prod = magnitude_of(lhs) * magnitude_of(rhs);
							quo = prod >> FRAC_BITS;
							if (prod[FRAC_BITS-1]) begin
								quo = quo + 64'd1;
							end
							value = apply_sign(neg, quo, sat);
						end
						default: begin
							if (rhs == '0) begin
								depth_cnt = 0;
								res.status = STS_DIVZERO;
							end else begin
								// quotient truncated toward zero
								quo = (magnitude_of(lhs) << FRAC_BITS) / magnitude_of(rhs);
								value = apply_sign(neg, quo, sat);
							end
						end
					endcase
					if (res.status == STS_OK) begin
						model_stack[depth_cnt] = value;
						depth_cnt++;
						if (sat) begin
							res.status = STS_SAT;
						end
					end
				end
			end
			FN_CLEAR: begin
				depth_cnt = 0;
			end
			default: ;
		endcase
		res.top_value = (depth_cnt > 0) ? model_stack[depth_cnt-1] : '0;
		res.stack_depth = DEPTH_W'(depth_cnt);
		return res;
	endfunction

	// send one word, with a random gap ahead of it
	task automatic send_word(func_t f, logic [DATA_W-1:0] opnd);
		if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.func    <= f;
		req_if.operand <= opnd;
		do @(posedge clk); while (!req_if.ready);
		pending_results.push_back(evaluate_word(f, opnd));
	endtask

	// input idles while the outstanding results come back
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_operand();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = DATA_W'($urandom_range(0, 16'hFFFF) + ($urandom_range(0, 8) << FRAC_BITS));
			2: begin
				case ($urandom_range(0, 3))
					0: v = VAL_MAX;
					1: v = VAL_MIN;
					2: v = Q_ONE;
					default: v = Q_LSB;
				endcase
			end
			3: v = '0;
			4: v = $urandom >> $urandom_range(0, 31);
			default: v = DATA_W'($urandom_range(0, 3) << FRAC_BITS);
		endcase
		if ($urandom_range(0, 1)) begin
			v = -v;
		end
		return v;
	endfunction

	// mostly well-formed postfix traffic, some noise words and fill bursts
	task automatic send_random_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_word(func_t'($urandom_range(0, 7)), $urandom);
		end else if (pick < 17) begin
			send_word(FN_CLEAR, $urandom);
		end else if (pick < 19) begin
			repeat (STACK_DEPTH + 1 - depth_cnt) send_word(FN_PUSH, rand_operand());
		end else if (depth_cnt < 2 ||
			(depth_cnt < STACK_DEPTH && $urandom_range(0, 99) < 40)) begin
			send_word(FN_PUSH, rand_operand());
		end else begin
			send_word(func_t'($urandom_range(FN_ADD, FN_DIV)), $urandom);
		end
	endtask

	task automatic test_push_extremes();
		send_word(FN_PUSH, VAL_MAX);
		send_word(FN_PUSH, VAL_MIN);
		send_word(FN_PUSH, Q_ALL_ONES);
		send_word(FN_PUSH, '0);
		send_word(FN_CLEAR, Q_ALL_ONES);
	endtask

	// empty stack, then a single entry
	task automatic test_missing_operand();
		send_word(FN_ADD, '0);
		send_word(FN_PUSH, Q_ONE);
		send_word(FN_DIV, '0);
	endtask

	task automatic test_saturation();
		send_word(FN_PUSH, VAL_MAX);
		send_word(FN_PUSH, Q_ONE);
		send_word(FN_ADD, '0);
		send_word(FN_PUSH, VAL_MIN);
		send_word(FN_SUB, '0);
		send_word(FN_PUSH, VAL_MIN);
		send_word(FN_MUL, '0);
	endtask

	// half-lsb products, positive and negative
	task automatic test_multiply_rounding();
		send_word(FN_CLEAR, '0);
		send_word(FN_PUSH, Q_LSB);
		send_word(FN_PUSH, Q_HALF);
		send_word(FN_MUL, '0);
		send_word(FN_PUSH, Q_NEG_HALF);
		send_word(FN_MUL, '0);
	endtask

	task automatic test_divide();
		send_word(FN_PUSH, '0);
		send_word(FN_DIV, '0);
		send_word(FN_PUSH, VAL_MIN);
		send_word(FN_PUSH, Q_ALL_ONES);
		send_word(FN_DIV, '0);
		send_word(FN_PUSH, Q_ONE);
		send_word(FN_PUSH, Q_NEG_THREE);
		send_word(FN_DIV, '0);
	endtask

	task automatic test_unused_codes();
		send_word(FN_SPARE_LO, $urandom);
		send_word(FN_SPARE_HI, $urandom);
	endtask

	// result side held off while pushes overflow the stack
	task automatic test_full_under_stall();
		hold_request = 1'b1;
		repeat (STACK_DEPTH + 2) send_word(FN_PUSH, rand_operand());
		wait_drained();
		send_word(FN_CLEAR, '0);
	endtask

	task automatic test_random_mix(int count);
		repeat (count) begin
			send_random_word();
			if ($urandom_range(0, 199) == 0) begin
				wait_drained();
			end
			if ($urandom_range(0, 499) == 0) begin
				hold_request = 1'b1;
			end
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		test_random_mix(250);
		idle_on = 1'b1;
	endtask

	task automatic finish_run();
		int waited;
		waited = 0;
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));
		end
		if (mismatch_count == 0) begin
			$display("rpn_stack_calculator verification clean");
		end else begin
			$display("rpn_stack_calculator verification failed");
		end
		$finish;
	endtask

	// result side: random ready, long hold on request
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_if.ready <= 1'b0;
			end else if (hold_request) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// compare each result word with the oldest prediction
	initial begin
		rpn_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result word, status %0d",
						rsp_if.status));
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.status !== want.status) begin
						report_mismatch($sformatf("status got %0d want %0d",
							rsp_if.status, want.status));
					end
					if (rsp_if.top_value !== want.top_value) begin
						report_mismatch($sformatf("top_value got %h want %h",
							rsp_if.top_value, want.top_value));
					end
					if (rsp_if.stack_depth !== want.stack_depth) begin
						report_mismatch($sformatf("stack_depth got %0d want %0d",
							rsp_if.stack_depth, want.stack_depth));
					end
				end
			end
		end
	end

	// reset, then the test sequence
	initial begin
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.func    <= FN_PUSH;
		req_if.operand <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_push_extremes();
		test_missing_operand();
		test_saturation();
		test_multiply_rounding();
		test_divide();
		test_unused_codes();
		test_full_under_stall();
		test_back_to_back();
		test_random_mix(1350);
		finish_run();
	end

endmodule
